// ===== hw/rtl/bilinear_grid_sampler_defines.svh =====
// Assertion macros shared by the bilinear grid sampler checkers.
// Included by bgs_checker.sv; expects clk in the including scope.
`ifndef BILINEAR_GRID_SAMPLER_DEFINES_SVH
`define BILINEAR_GRID_SAMPLER_DEFINES_SVH

// Same-cycle implication, disabled while dis is true.
`define BGS_ASSERT_IMPL(lbl, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("bilinear_grid_sampler: assertion failed");

// Next-cycle implication, disabled while dis is true.
`define BGS_ASSERT_NEXT(lbl, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("bilinear_grid_sampler: assertion failed");

`endif

// ===== hw/rtl/bgs_pkg.sv =====
// Package for the bilinear grid sampler: field widths, codes and constants.
// No dependencies; imported by the top level and the checker.
package bgs_pkg;

  // Fixed payload widths
  localparam int CELL_IDX_W = 7;
  localparam int HEIGHT_W   = 16;
  localparam int POS_W      = 17;
  localparam int OUT_W      = 24;

  // Configuration port
  localparam int CFG_W      = 8;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

  // Grid is split into four banks by column and row parity
  localparam int NUM_BANKS = 4;

  // Output saturation bounds
  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Register index, taken from paddr bit 2
  typedef enum logic {
    CFG_COLS = 1'b0,
    CFG_ROWS = 1'b1
  } cfg_idx_t;

endpackage

// ===== hw/rtl/bilinear_grid_sampler.sv =====
// Bilinear grid sampler: height grid in four parity banks, query pipeline.
// Accepts one item per cycle while busy is low; a query result strobes after the
// cell split, bank read, two multiply stages and round/saturate register.
// Reset starts a clearing pass over all ceil(GRID_COLS/2)*ceil(GRID_ROWS/2)
// addresses of each bank (4096 by default) that zeroes all banks; busy is high during it.
// Results cannot be stalled. Depends on bgs_pkg and bgs_ram.
module bilinear_grid_sampler #(
  parameter int GRID_COLS = 128,
  parameter int GRID_ROWS = 128,
  parameter int FRAC_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  bgs_pkg::op_t                         in_op,
  input  logic [bgs_pkg::CELL_IDX_W-1:0]       in_cell_col,
  input  logic [bgs_pkg::CELL_IDX_W-1:0]       in_cell_row,
  input  logic signed [bgs_pkg::HEIGHT_W-1:0]  in_cell_height,
  input  logic signed [bgs_pkg::POS_W-1:0]     in_pos_x,
  input  logic signed [bgs_pkg::POS_W-1:0]     in_pos_y,
  // result channel
  output logic                                 out_valid,
  output logic signed [bgs_pkg::OUT_W-1:0]     out_height_interp,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bgs_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [bgs_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [bgs_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);
  import bgs_pkg::*;

  localparam int XW         = $clog2(GRID_COLS);
  localparam int YW         = $clog2(GRID_ROWS);
  localparam int CI_W       = (XW > YW) ? XW : YW;
  localparam int HALF_COLS  = (GRID_COLS + 1) / 2;
  localparam int HALF_ROWS  = (GRID_ROWS + 1) / 2;
  localparam int BANK_DEPTH = HALF_COLS * HALF_ROWS;
  localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int WT_W       = FRAC_BITS + 2;
  localparam int RW         = HEIGHT_W + FRAC_BITS + 2;
  localparam int ACC_W      = RW + FRAC_BITS + 2;

  localparam logic [WT_W-1:0] ONE_W = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);

  typedef struct packed {
    logic [CI_W-1:0]      c0;
    logic [CI_W-1:0]      c1;
    logic [FRAC_BITS-1:0] w;
  } axis_t;

  // Register value 0 acts as 1, values past the grid act as the grid size
  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] r, input int lim);
    logic [CFG_W-1:0] s;
    if (r == '0) begin
      s = CFG_W'(1);
    end else if (int'(r) > lim) begin
      s = CFG_W'(lim);
    end else begin
      s = r;
    end
    return s;
  endfunction

  // Floor/ceiling cells with clamping, plus the fraction weight
  function automatic axis_t axis_split(input logic signed [POS_W-1:0] pos,
                                       input logic [CFG_W-1:0] size);
    logic signed [POS_W:0] fl;
    logic signed [POS_W:0] ce;
    logic signed [POS_W:0] last;
    axis_t a;
    fl   = (POS_W+1)'(pos >>> FRAC_BITS);
    ce   = fl + ((pos[FRAC_BITS-1:0] != '0) ? (POS_W+1)'(1) : (POS_W+1)'(0));
    last = signed'({{(POS_W+1-CFG_W){1'b0}}, size}) - (POS_W+1)'(1);
    if (fl < 0) begin
      a.c0 = '0;
      a.c1 = '0;
      a.w  = '0;
    end else if (ce > last) begin
      a.c0 = CI_W'(last);
      a.c1 = CI_W'(last);
      a.w  = '0;
    end else begin
      a.c0 = CI_W'(fl);
      a.c1 = CI_W'(ce);
      a.w  = pos[FRAC_BITS-1:0];
    end
    return a;
  endfunction

  // Address of a cell inside its parity bank
  function automatic logic [BA_W-1:0] bank_addr(input logic [CI_W-1:0] col,
                                                input logic [CI_W-1:0] row);
    return BA_W'(int'(row >> 1) * HALF_COLS + int'(col >> 1));
  endfunction

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [CFG_W-1:0] cols_in_use_r;
  logic [CFG_W-1:0] rows_in_use_r;
  logic             cfg_wr;
  cfg_idx_t         cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cfg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_in_use_r <= CFG_RESET;
      rows_in_use_r <= CFG_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_COLS: cols_in_use_r <= pwdata[CFG_W-1:0];
        CFG_ROWS: rows_in_use_r <= pwdata[CFG_W-1:0];
        default:  ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      CFG_COLS: prdata = {{(APB_DATA_W-CFG_W){1'b0}}, cols_in_use_r};
      CFG_ROWS: prdata = {{(APB_DATA_W-CFG_W){1'b0}}, rows_in_use_r};
      default:  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Clearing pass after reset
  // ---------------------------------------------------------------
  logic            clr_busy_r;
  logic [BA_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + BA_W'(1);
      if (clr_cnt_r == BA_W'(BANK_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign busy = clr_busy_r;

  // ---------------------------------------------------------------
  // Accept and write path
  // ---------------------------------------------------------------
  logic            accept;
  logic            wr_fire;
  logic [1:0]      wr_bank;
  logic [BA_W-1:0] wr_addr;
  logic [CI_W-1:0] wr_col;
  logic [CI_W-1:0] wr_row;

  assign accept  = start && !busy;
  assign wr_col  = CI_W'(in_cell_col);
  assign wr_row  = CI_W'(in_cell_row);
  assign wr_fire = accept && (in_op == OP_WRITE) &&
                   (int'(in_cell_col) < GRID_COLS) && (int'(in_cell_row) < GRID_ROWS);
  assign wr_bank = {wr_row[0], wr_col[0]};
  assign wr_addr = bank_addr(wr_col, wr_row);

  // ---------------------------------------------------------------
  // Stage 1: cells and weights
  // ---------------------------------------------------------------
  logic  s1_vld_r;
  axis_t s1_ax_r;
  axis_t s1_ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept && (in_op == OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_QUERY)) begin
      s1_ax_r <= axis_split(in_pos_x, eff_size(cols_in_use_r, GRID_COLS));
      s1_ay_r <= axis_split(in_pos_y, eff_size(rows_in_use_r, GRID_ROWS));
    end
  end

  // ---------------------------------------------------------------
  // Banked grid: one read per bank per cycle
  // ---------------------------------------------------------------
  logic [HEIGHT_W-1:0] bank_rd [NUM_BANKS];

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    localparam logic PC = 1'(b % 2);
    localparam logic PR = 1'(b / 2);
    logic [CI_W-1:0] rd_col;
    logic [CI_W-1:0] rd_row;
    logic            we;
    logic [BA_W-1:0] waddr;
    logic [HEIGHT_W-1:0] wdata;

    // Pick whichever cell of each axis has this bank's parity
    assign rd_col = (s1_ax_r.c0[0] == PC) ? s1_ax_r.c0 : s1_ax_r.c1;
    assign rd_row = (s1_ay_r.c0[0] == PR) ? s1_ay_r.c0 : s1_ay_r.c1;

    assign we    = clr_busy_r || (wr_fire && (wr_bank == 2'(b)));
    assign waddr = clr_busy_r ? clr_cnt_r : wr_addr;
    assign wdata = clr_busy_r ? '0 : in_cell_height;

    bgs_ram #(
      .WIDTH(HEIGHT_W),
      .DEPTH(BANK_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (we),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(bank_addr(rd_col, rd_row)),
      .rdata(bank_rd[b])
    );
  end

  // ---------------------------------------------------------------
  // Stage 2: bank data arrives; interpolate along x
  // ---------------------------------------------------------------
  logic                 s2_vld_r;
  logic                 s2_x0b_r, s2_x1b_r, s2_y0b_r, s2_y1b_r;
  logic [FRAC_BITS-1:0] s2_wx_r;
  logic [FRAC_BITS-1:0] s2_wy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_x0b_r <= s1_ax_r.c0[0];
    s2_x1b_r <= s1_ax_r.c1[0];
    s2_y0b_r <= s1_ay_r.c0[0];
    s2_y1b_r <= s1_ay_r.c1[0];
    s2_wx_r  <= s1_ax_r.w;
    s2_wy_r  <= s1_ay_r.w;
  end

  logic signed [HEIGHT_W-1:0] h00, h10, h01, h11;
  logic signed [WT_W-1:0]     wx_s, omx_s;
  logic signed [RW-1:0]       r1_nxt, r2_nxt;

  always_comb begin
    h00    = signed'(bank_rd[{s2_y0b_r, s2_x0b_r}]);
    h10    = signed'(bank_rd[{s2_y0b_r, s2_x1b_r}]);
    h01    = signed'(bank_rd[{s2_y1b_r, s2_x0b_r}]);
    h11    = signed'(bank_rd[{s2_y1b_r, s2_x1b_r}]);
    wx_s   = signed'({2'b00, s2_wx_r});
    omx_s  = signed'(ONE_W - {2'b00, s2_wx_r});
    r1_nxt = RW'(h00 * omx_s) + RW'(h10 * wx_s);
    r2_nxt = RW'(h01 * omx_s) + RW'(h11 * wx_s);
  end

  // ---------------------------------------------------------------
  // Stage 3: interpolate along y
  // ---------------------------------------------------------------
  logic                 s3_vld_r;
  logic signed [RW-1:0] s3_r1_r, s3_r2_r;
  logic [FRAC_BITS-1:0] s3_wy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_r1_r <= r1_nxt;
    s3_r2_r <= r2_nxt;
    s3_wy_r <= s2_wy_r;
  end

  logic signed [WT_W-1:0]  wy_s, omy_s;
  logic signed [ACC_W-1:0] acc_nxt;

  always_comb begin
    wy_s    = signed'({2'b00, s3_wy_r});
    omy_s   = signed'(ONE_W - {2'b00, s3_wy_r});
    acc_nxt = ACC_W'(s3_r1_r * omy_s) + ACC_W'(s3_r2_r * wy_s);
  end

  // ---------------------------------------------------------------
  // Stage 4: floor shift and saturation
  // ---------------------------------------------------------------
  logic                    s4_vld_r;
  logic signed [ACC_W-1:0] s4_acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_acc_r <= acc_nxt;
  end

  logic signed [ACC_W-1:0] res_shift;
  logic signed [ACC_W-1:0] res_sat;

  // Arithmetic shift rounds toward minus infinity
  always_comb begin
    res_shift = s4_acc_r >>> FRAC_BITS;
    if (res_shift > SAT_HI) begin
      res_sat = SAT_HI;
    end else if (res_shift < SAT_LO) begin
      res_sat = SAT_LO;
    end else begin
      res_sat = res_shift;
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_height_r <= res_sat[OUT_W-1:0];
  end

  assign out_valid         = out_valid_r;
  assign out_height_interp = out_height_r;

endmodule

// ===== hw/rtl/bgs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address collision. No dependencies.
module bgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, returns the old word on a collision
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bgs_checker.sv =====
// Port-level checker for the bilinear grid sampler, bound to the top level.
// Depends on bgs_pkg and bilinear_grid_sampler_defines.svh.
`include "bilinear_grid_sampler_defines.svh"

module bgs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              in_op,
  input logic                              out_valid,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [bgs_pkg::APB_ADDR_W-1:0]    paddr,
  input logic [bgs_pkg::APB_DATA_W-1:0]    pwdata,
  input logic [bgs_pkg::APB_DATA_W-1:0]    prdata
);
  import bgs_pkg::*;

  // Reset always restarts the clearing pass
  `BGS_ASSERT_NEXT(a_reset_clears, 1'b0, !rst_n, busy)

  // Every accepted query yields a result strobe on out_valid
  `BGS_ASSERT_IMPL(a_query_result, !rst_n, start && !busy && in_op == OP_QUERY, ##5 out_valid)

  // No result without a query accepted at the matching edge
  `BGS_ASSERT_IMPL(a_no_spurious, !rst_n, out_valid, $past(start && !busy && in_op == OP_QUERY, 5))

  // A column-register write is visible on an immediate readback
  `BGS_ASSERT_IMPL(a_cfg_readback, !rst_n, (psel && penable && pwrite && !paddr[2]) ##1 (psel && !pwrite && !paddr[2]), prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]))

endmodule

bind bilinear_grid_sampler bgs_checker u_bgs_checker (.*);
